// File: rtl/min_distance_feature_selector_top_defines.svh
// Assertion macros shared by the RTL.
`ifndef MIN_DISTANCE_FEATURE_SELECTOR_TOP_DEFINES_SVH
`define MIN_DISTANCE_FEATURE_SELECTOR_TOP_DEFINES_SVH

`ifndef SYNTHESIS
`define MDFS_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
`define MDFS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define MDFS_ASSERT_SAME(lbl, ante, cons, msg)
`define MDFS_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

// File: rtl/mdfs_pkg.sv
package mdfs_pkg;

  localparam int COORD_W   = 16;
  localparam int COUNT_W   = 13;
  localparam logic [COUNT_W-1:0] COUNT_SAT = 13'd4096;

  typedef logic signed [COORD_W-1:0] coord_t;

  typedef enum logic [1:0] {
    FUNC_START = 2'd0,
    FUNC_MARK  = 2'd1,
    FUNC_CAND  = 2'd2,
    FUNC_NONE  = 2'd3
  } func_t;

  typedef enum logic [2:0] {
    REG_IMAGE_ROWS   = 3'd0,
    REG_IMAGE_COLS   = 3'd1,
    REG_BORDER_WIDTH = 3'd2,
    REG_MIN_DISTANCE = 3'd3,
    REG_MAX_FEATURES = 3'd4,
    REG_MIN_SCORE    = 3'd5
  } reg_idx_t;

  typedef struct packed {
    logic [1:0]  func;
    logic [8:0]  pix_row;
    logic [9:0]  pix_col;
    logic [15:0] score;
  } in_word_t;

  typedef struct packed {
    logic               accepted;
    logic [COUNT_W-1:0] feature_count;
    logic               selection_done;
  } out_word_t;

  typedef struct packed {
    coord_t r0;
    coord_t r1;
    coord_t c0;
    coord_t c1;
  } rect_t;

endpackage

// File: rtl/mdfs_rect_clip.sv
module mdfs_rect_clip
  import mdfs_pkg::*;
(
  input  rect_t  raw,
  input  coord_t rows,
  input  coord_t cols,
  output rect_t  clip,
  output logic   empty
);

  always_comb begin
    clip.r0 = (raw.r0 < 0) ? '0 : raw.r0;
    clip.c0 = (raw.c0 < 0) ? '0 : raw.c0;
    clip.r1 = (raw.r1 > rows - coord_t'(1)) ? rows - coord_t'(1) : raw.r1;
    clip.c1 = (raw.c1 > cols - coord_t'(1)) ? cols - coord_t'(1) : raw.c1;
    empty   = (clip.r0 > clip.r1) || (clip.c0 > clip.c1);
  end

endmodule

// File: rtl/min_distance_feature_selector_top.sv
// Channel  | Direction | Handshake                    | Payload
// input    | in        | start && !busy               | in_word (in_word_t)
// result   | out       | out_valid, one-cycle strobe  | out_word (out_word_t)
// config   | in        | psel, penable, pwrite, pready| paddr, pwdata, prdata
//
// One word in flight at a time; busy stays high until its result strobes.
// Rejected candidate: states CHK, DEC and REPORT lie between the accept edge and the strobe; unused code: REPORT only.
// Square clear: RSET and REND per rectangle plus, per clipped row, ROW and then RD and WR per touched word.
// Frame start: a fill pass over all MASK_WORDS (8192) words, then the four border bands the same way.
// After reset a fill pass over all MASK_WORDS words runs with busy high; the receiver cannot stall.
`include "min_distance_feature_selector_top_defines.svh"

module min_distance_feature_selector_top
  import mdfs_pkg::*;
#(
  parameter int MAX_ROWS       = 512,
  parameter int MAX_COLS       = 1024,
  parameter int MASK_WORD_BITS = 64,
  parameter int MAX_RADIUS     = 31
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  in_word_t    in_word,
  output logic        out_valid,
  output out_word_t   out_word,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int WB         = MASK_WORD_BITS;
  localparam int L          = $clog2(WB);
  localparam int MASK_WORDS = (MAX_ROWS * MAX_COLS + WB - 1) / WB;
  localparam int AW         = $clog2(MASK_WORDS);
  localparam int IXW        = AW + L;

  typedef enum logic [9:0] {
    ST_IDLE   = 10'b00_0000_0001,
    ST_FILL   = 10'b00_0000_0010,
    ST_RSET   = 10'b00_0000_0100,
    ST_ROW    = 10'b00_0000_1000,
    ST_RD     = 10'b00_0001_0000,
    ST_WR     = 10'b00_0010_0000,
    ST_REND   = 10'b00_0100_0000,
    ST_CHK    = 10'b00_1000_0000,
    ST_DEC    = 10'b01_0000_0000,
    ST_REPORT = 10'b10_0000_0000
  } state_t;

  state_t state_r;

  logic [9:0]  image_rows_r;
  logic [10:0] image_cols_r;
  logic [7:0]  border_width_r;
  logic [4:0]  min_distance_r;
  logic [12:0] max_features_r;
  logic [15:0] min_score_r;

  in_word_t           item_r;
  logic [COUNT_W-1:0] count_r;
  logic               done_r;
  logic               acc_r;
  logic               frame_r;
  logic               sq_r;
  logic [1:0]         bk_r;
  logic [AW-1:0]      fill_addr_r;
  coord_t             rcur_r, r1_r, c0_r, c1_r;
  logic [IXW-1:0]     idx0_r, idx1_r;
  logic [AW-1:0]      w_r, we_r;
  logic [L-1:0]       bitsel_r;
  logic [WB-1:0]      rdata_r;
  logic               out_valid_r;
  out_word_t          out_word_r;

  logic [WB-1:0] mask_mem [MASK_WORDS];

  coord_t rows_act, cols_act, rad, bw, prow, pcol;
  rect_t  raw_rect, clip_rect;
  logic   clip_empty;

  assign rows_act = (coord_t'(image_rows_r) > coord_t'(MAX_ROWS)) ?
                    coord_t'(MAX_ROWS) : coord_t'(image_rows_r);
  assign cols_act = (coord_t'(image_cols_r) > coord_t'(MAX_COLS)) ?
                    coord_t'(MAX_COLS) : coord_t'(image_cols_r);
  assign rad      = (coord_t'(min_distance_r) > coord_t'(MAX_RADIUS)) ?
                    coord_t'(MAX_RADIUS) : coord_t'(min_distance_r);
  assign bw       = coord_t'(border_width_r);
  assign prow     = coord_t'(item_r.pix_row);
  assign pcol     = coord_t'(item_r.pix_col);

  always_comb begin
    raw_rect = '{r0: '0, r1: rows_act - coord_t'(1), c0: '0, c1: cols_act - coord_t'(1)};
    if (sq_r) begin
      raw_rect = '{r0: prow - rad, r1: prow + rad, c0: pcol - rad, c1: pcol + rad};
    end else begin
      unique case (bk_r)
        2'd0: raw_rect.r1 = bw - coord_t'(1);
        2'd1: raw_rect.r0 = rows_act - bw;
        2'd2: raw_rect.c1 = bw - coord_t'(1);
        2'd3: raw_rect.c0 = cols_act - bw;
        default: ;
      endcase
    end
  end

  mdfs_rect_clip u_clip (
    .raw   (raw_rect),
    .rows  (rows_act),
    .cols  (cols_act),
    .clip  (clip_rect),
    .empty (clip_empty)
  );

  // shared index unit: row * MAX_COLS + column
  logic [IXW-1:0] mul_row, base, cand_idx, row_lo, row_hi;
  assign mul_row  = (state_r == ST_CHK) ? IXW'(item_r.pix_row) : IXW'(unsigned'(rcur_r));
  assign base     = mul_row * IXW'(MAX_COLS);
  assign cand_idx = base + IXW'(item_r.pix_col);
  assign row_lo   = base + IXW'(unsigned'(c0_r));
  assign row_hi   = base + IXW'(unsigned'(c1_r));

  logic [WB-1:0] clr;
  always_comb begin
    for (int b = 0; b < WB; b++) begin
      clr[b] = ({w_r, L'(b)} >= idx0_r) && ({w_r, L'(b)} <= idx1_r);
    end
  end

  logic               mem_we, mem_re;
  logic [AW-1:0]      mem_waddr, mem_raddr;
  logic [WB-1:0]      mem_wdata;
  assign mem_we    = (state_r == ST_FILL) || (state_r == ST_WR);
  assign mem_waddr = (state_r == ST_FILL) ? fill_addr_r : w_r;
  assign mem_wdata = (state_r == ST_FILL) ? '1 : (rdata_r & ~clr);
  assign mem_re    = (state_r == ST_RD) || (state_r == ST_CHK);
  assign mem_raddr = (state_r == ST_CHK) ? cand_idx[IXW-1:L] : w_r;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mask_mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata_r <= mask_mem[mem_raddr];
    end
  end

  logic               in_img, pass;
  logic [COUNT_W-1:0] cnt_inc;
  assign in_img  = (prow < rows_act) && (pcol < cols_act);
  assign pass    = in_img && (item_r.score > min_score_r) && !done_r && rdata_r[bitsel_r];
  assign cnt_inc = (count_r == COUNT_SAT) ? count_r : count_r + 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= ST_FILL;
      fill_addr_r    <= '0;
      frame_r        <= 1'b0;
      sq_r           <= 1'b0;
      bk_r           <= '0;
      count_r        <= '0;
      done_r         <= 1'b0;
      acc_r          <= 1'b0;
      out_valid_r    <= 1'b0;
      image_rows_r   <= 10'd480;
      image_cols_r   <= 11'd640;
      border_width_r <= 8'd0;
      min_distance_r <= 5'd8;
      max_features_r <= 13'd200;
      min_score_r    <= 16'd0;
    end else begin
      out_valid_r <= 1'b0;
      if (psel && penable && pwrite) begin
        unique case (paddr[4:2])
          REG_IMAGE_ROWS:   image_rows_r   <= pwdata[9:0];
          REG_IMAGE_COLS:   image_cols_r   <= pwdata[10:0];
          REG_BORDER_WIDTH: border_width_r <= pwdata[7:0];
          REG_MIN_DISTANCE: min_distance_r <= pwdata[4:0];
          REG_MAX_FEATURES: max_features_r <= pwdata[12:0];
          REG_MIN_SCORE:    min_score_r    <= pwdata[15:0];
          default: ;
        endcase
      end
      unique case (state_r)
        ST_IDLE: begin
          if (start) begin
            item_r <= in_word;
            acc_r  <= 1'b0;
            unique case (in_word.func)
              FUNC_START: begin
                frame_r     <= 1'b1;
                fill_addr_r <= '0;
                count_r     <= '0;
                done_r      <= 1'b0;
                state_r     <= ST_FILL;
              end
              FUNC_MARK: begin
                count_r <= cnt_inc;
                sq_r    <= 1'b1;
                state_r <= ST_RSET;
              end
              FUNC_CAND: state_r <= ST_CHK;
              default:   state_r <= ST_REPORT;
            endcase
          end
        end
        ST_FILL: begin
          fill_addr_r <= fill_addr_r + 1'b1;
          if (fill_addr_r == AW'(MASK_WORDS - 1)) begin
            sq_r    <= 1'b0;
            bk_r    <= '0;
            state_r <= frame_r ? ST_RSET : ST_IDLE;
          end
        end
        ST_RSET: begin
          rcur_r  <= clip_rect.r0;
          r1_r    <= clip_rect.r1;
          c0_r    <= clip_rect.c0;
          c1_r    <= clip_rect.c1;
          state_r <= clip_empty ? ST_REND : ST_ROW;
        end
        ST_ROW: begin
          idx0_r  <= row_lo;
          idx1_r  <= row_hi;
          w_r     <= row_lo[IXW-1:L];
          we_r    <= row_hi[IXW-1:L];
          state_r <= ST_RD;
        end
        ST_RD: state_r <= ST_WR;
        ST_WR: begin
          if (w_r == we_r) begin
            if (rcur_r == r1_r) begin
              state_r <= ST_REND;
            end else begin
              rcur_r  <= rcur_r + coord_t'(1);
              state_r <= ST_ROW;
            end
          end else begin
            w_r     <= w_r + 1'b1;
            state_r <= ST_RD;
          end
        end
        ST_REND: begin
          if (sq_r || bk_r == 2'd3) begin
            state_r <= ST_REPORT;
          end else begin
            bk_r    <= bk_r + 1'b1;
            state_r <= ST_RSET;
          end
        end
        ST_CHK: begin
          bitsel_r <= cand_idx[L-1:0];
          state_r  <= ST_DEC;
        end
        ST_DEC: begin
          if (pass) begin
            acc_r   <= 1'b1;
            count_r <= cnt_inc;
            if (cnt_inc >= max_features_r) begin
              done_r  <= 1'b1;
              state_r <= ST_REPORT;
            end else begin
              sq_r    <= 1'b1;
              state_r <= ST_RSET;
            end
          end else begin
            state_r <= ST_REPORT;
          end
        end
        ST_REPORT: begin
          out_valid_r <= 1'b1;
          out_word_r  <= '{accepted: acc_r, feature_count: count_r,
                           selection_done: done_r};
          state_r     <= ST_IDLE;
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[4:2])
      REG_IMAGE_ROWS:   prdata = 32'(image_rows_r);
      REG_IMAGE_COLS:   prdata = 32'(image_cols_r);
      REG_BORDER_WIDTH: prdata = 32'(border_width_r);
      REG_MIN_DISTANCE: prdata = 32'(min_distance_r);
      REG_MAX_FEATURES: prdata = 32'(max_features_r);
      REG_MIN_SCORE:    prdata = 32'(min_score_r);
      default:          prdata = '0;
    endcase
  end

  assign pready    = 1'b1;
  assign busy      = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

  `MDFS_ASSERT_SAME(a_strobe_src, out_valid, $past(state_r == ST_REPORT), "strobe without report")
  `MDFS_ASSERT_SAME(a_done_src, $rose(done_r), $past(state_r == ST_DEC), "done set outside decision")
  `MDFS_ASSERT_SAME(a_word_range, state_r == ST_WR, w_r <= we_r, "word walk overran row")
  `MDFS_ASSERT_SAME(a_acc_count, out_valid && out_word.accepted, |out_word.feature_count, "zero count")

endmodule

// File: verif/tb_top.sv
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import mdfs_pkg::*;

  localparam int ROWS_CAP = 512;
  localparam int COLS_CAP = 1024;
  localparam int RAD_CAP  = 31;
  localparam int SAT      = 4096;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  in_word_t    in_word = '0;
  logic        out_valid;
  out_word_t   out_word;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [4:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  min_distance_feature_selector_top dut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // shadow registers and selector state
  int unsigned rows_reg, cols_reg, border_reg, dist_reg, maxf_reg, thresh_reg;
  bit [COLS_CAP-1:0] allow_map [ROWS_CAP];
  int unsigned feat_count;
  bit          sel_done;

  out_word_t result_q [$];
  int errors, words_sent, picks, frames, checked;
  bit burst;

  function automatic int eff_rows();
    return (rows_reg > ROWS_CAP) ? ROWS_CAP : rows_reg;
  endfunction

  function automatic int eff_cols();
    return (cols_reg > COLS_CAP) ? COLS_CAP : cols_reg;
  endfunction

  function automatic void clear_box(int r0, int r1, int c0, int c1);
    if (r0 < 0) r0 = 0;
    if (c0 < 0) c0 = 0;
    if (r1 > eff_rows() - 1) r1 = eff_rows() - 1;
    if (c1 > eff_cols() - 1) c1 = eff_cols() - 1;
    for (int r = r0; r <= r1; r++)
      for (int c = c0; c <= c1; c++) allow_map[r][c] = 1'b0;
  endfunction

  function automatic void clear_near(int r, int c);
    int rad;
    rad = (dist_reg > RAD_CAP) ? RAD_CAP : dist_reg;
    clear_box(r - rad, r + rad, c - rad, c + rad);
  endfunction

  function automatic out_word_t select_step(in_word_t w);
    out_word_t o;
    int rows, cols, bw, r, c;
    bit acc;
    rows = eff_rows();
    cols = eff_cols();
    bw = border_reg;
    r = int'(w.pix_row);
    c = int'(w.pix_col);
    acc = 1'b0;
    case (func_t'(w.func))
      FUNC_START: begin
        for (int i = 0; i < ROWS_CAP; i++) allow_map[i] = '1;
        if (bw > 0) begin
          clear_box(0, bw - 1, 0, cols - 1);
          clear_box(rows - bw, rows - 1, 0, cols - 1);
          clear_box(0, rows - 1, 0, bw - 1);
          clear_box(0, rows - 1, cols - bw, cols - 1);
        end
        feat_count = 0;
        sel_done = 1'b0;
      end
      FUNC_MARK: begin
        clear_near(r, c);
        if (feat_count < SAT) feat_count++;
      end
      FUNC_CAND: begin
        if (r < rows && c < cols && w.score > thresh_reg && !sel_done && allow_map[r][c]) begin
          acc = 1'b1;
          if (feat_count < SAT) feat_count++;
          if (feat_count >= maxf_reg) sel_done = 1'b1;
          else clear_near(r, c);
        end
      end
      default: ;
    endcase
    o.accepted = acc;
    o.feature_count = feat_count[COUNT_W-1:0];
    o.selection_done = sel_done;
    return o;
  endfunction

  always @(posedge clk) begin
    out_word_t exp_w;
    if (rst_n && out_valid) begin
      if (result_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected word, expected none, actual %p", $realtime, out_word);
      end else begin
        exp_w = result_q.pop_front();
        checked++;
        if (out_word.accepted !== exp_w.accepted ||
            out_word.feature_count !== exp_w.feature_count ||
            out_word.selection_done !== exp_w.selection_done) begin
          errors++;
          $display("%0t: mismatch, expected %p, actual %p", $realtime, exp_w, out_word);
        end
      end
    end
  end

  function automatic in_word_t mk(func_t f, int r, int c, int s);
    in_word_t w;
    bit [31:0] rb, cb, sb;
    rb = r;
    cb = c;
    sb = s;
    w.func = f;
    w.pix_row = rb[8:0];
    w.pix_col = cb[9:0];
    w.score = sb[15:0];
    return w;
  endfunction

  task automatic send_word(in_word_t w);
    int gap;
    gap = burst ? 0 : $urandom_range(0, 6);
    @(negedge clk);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    start <= 1'b1;
    in_word <= w;
    @(posedge clk);
    while (busy) @(posedge clk);
    result_q.push_back(select_step(w));
    if (result_q[$].accepted) picks++;
    if (w.func == FUNC_START) frames++;
    words_sent++;
  endtask

  task automatic drain();
    @(negedge clk);
    start <= 1'b0;
    while (result_q.size() != 0) @(posedge clk);
    while (busy) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(reg_idx_t idx, int unsigned v);
    @(negedge clk);
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= {idx, 2'b00};
    pwdata <= v;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    case (idx)
      REG_IMAGE_ROWS:   rows_reg = v & 32'h3ff;
      REG_IMAGE_COLS:   cols_reg = v & 32'h7ff;
      REG_BORDER_WIDTH: border_reg = v & 32'hff;
      REG_MIN_DISTANCE: dist_reg = v & 32'h1f;
      REG_MAX_FEATURES: maxf_reg = v & 32'h1fff;
      REG_MIN_SCORE:    thresh_reg = v & 32'hffff;
      default: ;
    endcase
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic set_all(int unsigned r, int unsigned c, int unsigned b, int unsigned d,
                         int unsigned m, int unsigned s);
    write_reg(REG_IMAGE_ROWS, r);
    write_reg(REG_IMAGE_COLS, c);
    write_reg(REG_BORDER_WIDTH, b);
    write_reg(REG_MIN_DISTANCE, d);
    write_reg(REG_MAX_FEATURES, m);
    write_reg(REG_MIN_SCORE, s);
  endtask

  task automatic test_defaults();
    send_word(mk(FUNC_START, 0, 0, 0));
    send_word(mk(FUNC_CAND, 0, 0, 0));
    send_word(mk(FUNC_CAND, 0, 0, 16'hffff));
    send_word(mk(FUNC_CAND, 1, 1, 16'hfff0));
    send_word(mk(FUNC_CAND, 479, 639, 16'hff00));
    send_word(mk(FUNC_CAND, 480, 0, 16'hfe00));
    send_word(mk(FUNC_CAND, 511, 1023, 16'hfd00));
    send_word(mk(FUNC_NONE, 511, 1023, 16'hffff));
    send_word(mk(FUNC_MARK, 0, 0, 0));
    send_word(mk(FUNC_MARK, 511, 1023, 16'hffff));
    drain();
  endtask

  task automatic test_extremes();
    // wide border, top threshold
    set_all(16, 16, 255, 31, 1, 65535);
    send_word(mk(FUNC_START, 0, 0, 0));
    send_word(mk(FUNC_CAND, 5, 5, 16'hffff));
    drain();
    // empty image
    set_all(0, 16, 0, 0, 4096, 0);
    send_word(mk(FUNC_START, 0, 0, 0));
    send_word(mk(FUNC_CAND, 0, 0, 16'hffff));
    send_word(mk(FUNC_MARK, 0, 0, 1));
    drain();
    // oversized image, zero max features
    set_all(1023, 2047, 1, 0, 0, 0);
    send_word(mk(FUNC_START, 0, 0, 0));
    send_word(mk(FUNC_CAND, 511, 1023, 16'hffff));
    send_word(mk(FUNC_CAND, 1, 1, 16'hff00));
    send_word(mk(FUNC_CAND, 2, 2, 16'hfe00));
    drain();
    // marks reaching the maximum
    set_all(32, 32, 0, 3, 2, 100);
    send_word(mk(FUNC_START, 0, 0, 0));
    send_word(mk(FUNC_MARK, 10, 10, 0));
    send_word(mk(FUNC_MARK, 20, 20, 0));
    send_word(mk(FUNC_CAND, 30, 30, 16'h8000));
    send_word(mk(FUNC_CAND, 0, 0, 16'h7000));
    drain();
  endtask

  task automatic test_count_limit();
    // maximum above anything reached, then a maximum passed by marks alone
    set_all(1, 1, 0, 0, 8191, 0);
    send_word(mk(FUNC_START, 0, 0, 0));
    burst = 1'b1;
    repeat (20) send_word(mk(FUNC_MARK, 0, 5, 0));
    burst = 1'b0;
    send_word(mk(FUNC_CAND, 0, 0, 16'hffff));
    drain();
    write_reg(REG_MAX_FEATURES, 12);
    send_word(mk(FUNC_START, 0, 0, 0));
    burst = 1'b1;
    repeat (20) send_word(mk(FUNC_MARK, 0, 5, 0));
    burst = 1'b0;
    send_word(mk(FUNC_CAND, 0, 0, 16'hffff));
    send_word(mk(FUNC_CAND, 0, 0, 16'hfff0));
    drain();
  endtask

  task automatic random_frame(int n, bit full_size);
    int rows, cols, sc, k, r, c;
    if (full_size) set_all(512, 1024, $urandom_range(1, 4), $urandom_range(0, 31),
                           $urandom_range(20, 80), $urandom_range(0, 1000));
    else set_all($urandom_range(1, 64), $urandom_range(1, 128),
                 ($urandom_range(0, 9) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 6),
                 $urandom_range(0, 31),
                 ($urandom_range(0, 5) == 0) ? $urandom_range(0, 8191) : $urandom_range(1, 40),
                 ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 40000));
    burst = ($urandom_range(0, 3) == 0);
    rows = eff_rows();
    cols = eff_cols();
    sc = 65535;
    send_word(mk(FUNC_START, 0, 0, 0));
    repeat (n) begin
      k = $urandom_range(0, 99);
      r = (rows > 0) ? $urandom_range(0, rows - 1) : 0;
      c = (cols > 0) ? $urandom_range(0, cols - 1) : 0;
      if (k < 70) begin
        sc = sc - $urandom_range(0, 700);
        if (sc < 0) sc = 0;
        send_word(mk(FUNC_CAND, r, c, sc));
      end else if (k < 84) begin
        send_word(mk(FUNC_MARK, r + $urandom_range(0, 3), c + $urandom_range(0, 3),
                     $urandom_range(0, 65535)));
      end else if (k < 99) begin
        send_word(mk(func_t'($urandom_range(1, 3)), $urandom_range(0, 511),
                     $urandom_range(0, 1023), $urandom_range(0, 65535)));
      end else if (!full_size) begin
        sc = 65535;
        send_word(mk(FUNC_START, r, c, $urandom_range(0, 65535)));
      end
    end
    drain();
  endtask

  task automatic test_random();
    for (int p = 0; p < 12; p++) random_frame(75, p == 5);
  endtask

  initial begin
    rows_reg = 480;
    cols_reg = 640;
    border_reg = 0;
    dist_reg = 8;
    maxf_reg = 200;
    thresh_reg = 0;
    for (int i = 0; i < ROWS_CAP; i++) allow_map[i] = '1;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    test_defaults();
    test_extremes();
    test_count_limit();
    test_random();
    $display("covered %0d words over %0d frame starts, %0d candidates picked, %0d results checked",
             words_sent, frames, picks, checked);
    $display("directed limits, count past the maximum and random descending-score frames");
    if (errors == 0 && result_q.size() == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end

  initial begin
    #40ms;
    $display("status: fail");
    $finish;
  end

endmodule

// File: min_distance_feature_selector_top.f
+incdir+rtl
rtl/mdfs_pkg.sv
rtl/mdfs_rect_clip.sv
rtl/min_distance_feature_selector_top.sv
verif/tb_top.sv
